### rtl/fir_lp_pkg.sv
// ----------------------------------------------------------------------------
// fir_lp_pkg
// shared types, constants and the coefficient rom of the 22-tap low-pass fir
// ----------------------------------------------------------------------------
package fir_lp_pkg;

  // converter sample and filter output
  localparam int unsigned IN_W     = 12;
  localparam int unsigned OUT_W    = 18;
  localparam int          OUT_LOW  = -32768;
  localparam int          OUT_HIGH = 131071;

  // coefficient rom, signed q1.23
  localparam int unsigned ROM_TAPS  = 22;
  localparam int unsigned ROM_W     = 24;
  localparam int unsigned ROM_FRAC  = 23;
  localparam int unsigned ROM_IDX_W = 6;

  localparam logic signed [ROM_W-1:0] COEFF_ROM [ROM_TAPS] = '{
    -24'sd20040, -24'sd27808, -24'sd38702, -24'sd34947, 24'sd12145, 24'sd129935,
    24'sd329235, 24'sd593276, 24'sd876901, 24'sd1117838, 24'sd1256472,
    24'sd1256472, 24'sd1117838, 24'sd876901, 24'sd593276, 24'sd329235,
    24'sd129935, 24'sd12145, -24'sd34947, -24'sd38702, -24'sd27808, -24'sd20040
  };

  // control that travels alongside one tap through the mac pipeline
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

  // coefficient j requantized to cw bits, rounding half up; zero past the rom
  function automatic logic signed [ROM_W-1:0] coeff_at(
    input logic [ROM_IDX_W-1:0] j,
    input int unsigned          cw
  );
    logic signed [ROM_W:0] v;
    int unsigned           s;
    s = ROM_FRAC + 1 - cw;
    if (j >= ROM_IDX_W'(ROM_TAPS)) return '0;
    if (s == 0) return COEFF_ROM[j[4:0]];
    v = {COEFF_ROM[j[4:0]][ROM_W-1], COEFF_ROM[j[4:0]]};
    v = v + ((ROM_W+1)'(1) << (s - 1));
    v = v >>> s;
    return v[ROM_W-1:0];
  endfunction

endpackage

### rtl/fir_lp_dline.sv
// ----------------------------------------------------------------------------
// fir_lp_dline
// circular delay line memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module fir_lp_dline #(
  parameter int unsigned DEPTH  = 22,
  parameter int unsigned ADDR_W = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [ADDR_W-1:0]           wr_addr_i,
  input  logic [fir_lp_pkg::IN_W-1:0] wr_data_i,
  input  logic                        rd_en_i,
  input  logic [ADDR_W-1:0]           rd_addr_i,
  output logic [fir_lp_pkg::IN_W-1:0] rd_data_o
);
  import fir_lp_pkg::*;

  logic [IN_W-1:0]  mem_q [DEPTH];
  logic [IN_W-1:0]  rd_data_q;
  logic [DEPTH-1:0] vld_q;
  logic             rd_vld_q;

  // sample storage, no reset
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // per-entry written flags, an unwritten entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

### rtl/fir_lp_mac.sv
// ----------------------------------------------------------------------------
// fir_lp_mac
// shared multiply-accumulate: coefficient register, product register, sum
// ----------------------------------------------------------------------------
module fir_lp_mac #(
  parameter int unsigned COEFF_WIDTH = 16,
  parameter int unsigned ACC_W       = 34
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fir_lp_pkg::mac_ctl_t          issue_i,
  input  logic signed [COEFF_WIDTH-1:0] coef_i,
  input  logic [fir_lp_pkg::IN_W-1:0]   data_i,
  output logic signed [ACC_W-1:0]       acc_o,
  output logic                          done_o
);
  import fir_lp_pkg::*;

  localparam int unsigned PROD_W = COEFF_WIDTH + IN_W + 1;

  mac_ctl_t                  ctl1_q, ctl2_q;
  logic signed [COEFF_WIDTH-1:0] coef_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q, acc_d, prod_ext;
  logic                      done_q, done_d;

  assign prod_ext = $signed({{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q});

  always_comb begin
    acc_d = (ctl2_q.first ? '0 : acc_q) + prod_ext;
    if (issue_i.valid && issue_i.first) begin
      done_d = 1'b0;
    end else if (ctl2_q.valid && ctl2_q.last) begin
      done_d = 1'b1;
    end else begin
      done_d = done_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      done_q <= 1'b0;
    end else begin
      ctl1_q <= issue_i;
      ctl2_q <= ctl1_q;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i.valid) begin
      coef_q <= coef_i;
    end
    if (ctl1_q.valid) begin
      prod_q <= coef_q * $signed({1'b0, data_i});
    end
    if (ctl2_q.valid) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule

### rtl/fir_lowpass_22tap.sv
// ----------------------------------------------------------------------------
// fir_lowpass_22tap
// direct-form fir low-pass over 12-bit converter samples, delay line in memory
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------
//   in      | input     | in_valid_i / in_stall_o  | sample_i   12 b unsigned
//   out     | output    | out_valid_o / out_stall_i| filtered_o 18 b signed, q.4
//
// one beat in gives one beat out; the single read port of the delay line memory
// sets the pace: one tap is read per cycle, then the mac pipeline drains
// a new sample is taken while the previous result still waits in the output
// register; the result of that sample then waits until out is free
// reset clears the write slot, the entry-written flags and all handshake state,
// so the delay line reads as all zeros right after reset with no clearing pass
//
module fir_lowpass_22tap #(
  parameter int unsigned TAPS        = 22,
  parameter int unsigned COEFF_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [fir_lp_pkg::IN_W-1:0]         sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [fir_lp_pkg::OUT_W-1:0] filtered_o
);
  import fir_lp_pkg::*;

  localparam int unsigned TAP_W = $clog2(TAPS);
  localparam int unsigned ACC_W = COEFF_WIDTH + IN_W + 1 + TAP_W;
  localparam int unsigned SHIFT = COEFF_WIDTH - 5;

  localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(TAPS - 1);

  localparam logic signed [ACC_W:0] RND_HALF = (ACC_W+1)'(1) << (SHIFT - 1);
  localparam logic signed [ACC_W:0] SAT_LO   = (ACC_W+1)'(OUT_LOW);
  localparam logic signed [ACC_W:0] SAT_HI   = (ACC_W+1)'(OUT_HIGH);

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [TAP_W-1:0] slot_q, slot_d;      // where the next sample goes
  logic [TAP_W-1:0] rd_idx_q, rd_idx_d;  // delay entry of the current tap
  logic [TAP_W-1:0] tap_q, tap_d;        // coefficient index of the current tap

  logic                     in_acc;
  logic                     out_load;
  mac_ctl_t                 issue;
  logic signed [ROM_W-1:0]  coef_full;
  logic signed [COEFF_WIDTH-1:0] coef;
  logic [IN_W-1:0]          rd_data;
  logic signed [ACC_W-1:0]  acc;
  logic                     mac_done;

  logic signed [ACC_W:0]    rnd_sum, rnd_val;
  logic signed [OUT_W-1:0]  filtered_d, filtered_q;
  logic                     out_valid_q, out_valid_d;

  // ---- handshake --------------------------------------------------------
  // input is taken only between items; out has its own register
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // ---- tap sequencer ----------------------------------------------------
  // walks the delay line backward from the newest sample, one read a cycle
  always_comb begin
    state_d  = state_q;
    slot_d   = slot_q;
    rd_idx_d = rd_idx_q;
    tap_d    = tap_q;
    issue    = '0;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d  = ST_RUN;
          rd_idx_d = slot_q;
          tap_d    = '0;
          slot_d   = (slot_q == TAP_LAST) ? '0 : slot_q + 1'b1;
        end
      end
      ST_RUN: begin
        issue.valid = 1'b1;
        issue.first = (tap_q == '0);
        issue.last  = (tap_q == TAP_LAST);
        rd_idx_d    = (rd_idx_q == '0) ? TAP_LAST : rd_idx_q - 1'b1;
        tap_d       = tap_q + 1'b1;
        if (tap_q == TAP_LAST) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // sum complete and out register free or emptying this cycle
        if (mac_done && (!out_valid_q || !out_stall_i)) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      slot_q   <= '0;
      rd_idx_q <= '0;
      tap_q    <= '0;
    end else begin
      state_q  <= state_d;
      slot_q   <= slot_d;
      rd_idx_q <= rd_idx_d;
      tap_q    <= tap_d;
    end
  end

  // coefficient for the tap being issued, registered inside the mac
  assign coef_full = coeff_at(ROM_IDX_W'(tap_q), COEFF_WIDTH);
  assign coef      = coef_full[COEFF_WIDTH-1:0];

  // ---- delay line memory ------------------------------------------------
  // new sample written on the accept edge, first read in the next cycle
  fir_lp_dline #(
    .DEPTH  (TAPS),
    .ADDR_W (TAP_W)
  ) u_dline (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (in_acc),
    .wr_addr_i (slot_q),
    .wr_data_i (sample_i),
    .rd_en_i   (issue.valid),
    .rd_addr_i (rd_idx_q),
    .rd_data_o (rd_data)
  );

  // ---- multiply-accumulate ----------------------------------------------
  fir_lp_mac #(
    .COEFF_WIDTH (COEFF_WIDTH),
    .ACC_W       (ACC_W)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (issue),
    .coef_i  (coef),
    .data_i  (rd_data),
    .acc_o   (acc),
    .done_o  (mac_done)
  );

  // ---- scale to 4 fraction bits, round half up, saturate -----------------
  always_comb begin
    rnd_sum = $signed({acc[ACC_W-1], acc}) + RND_HALF;
    rnd_val = rnd_sum >>> SHIFT;
    if (rnd_val < SAT_LO) begin
      filtered_d = OUT_W'(OUT_LOW);
    end else if (rnd_val > SAT_HI) begin
      filtered_d = OUT_W'(OUT_HIGH);
    end else begin
      filtered_d = rnd_val[OUT_W-1:0];
    end
  end

  // ---- output register --------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      filtered_q <= filtered_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = filtered_q;

  // ---- checks -----------------------------------------------------------
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= TAP_LAST && rd_idx_q <= TAP_LAST)
    else $error("delay line index out of range");

  a_accept_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_RUN) && (tap_q == '0) && (rd_idx_q == $past(slot_q)))
    else $error("accepted beat did not start a tap walk at its own slot");

  a_load_needs_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> mac_done && !(issue.valid))
    else $error("output loaded before the sum was complete");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q && $stable(filtered_q))
    else $error("stalled result was overwritten");

endmodule
